@@ rtl/ssb_pkg.sv @@
`timescale 1ns / 1ps
// ssb_pkg: shared types and constants for the subpixel span blend unit
// no dependencies; imported by every module in rtl/

package ssb_pkg;

  // pixel store geometry
  localparam int unsigned PIXELS   = 1024;
  localparam int unsigned PIX_AW   = $clog2(PIXELS);

  // field widths fixed by the interface
  localparam int unsigned LOC_W    = 17;
  localparam int unsigned SPAN_W   = 16;
  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned PREC_W   = 3;
  localparam int unsigned AMT_W    = 8;   // holds 2^precision, up to 128
  localparam int unsigned CH_W     = 8;
  localparam int unsigned STEP_W   = $clog2(LOC_W);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [PREC_W-1:0] PREC_RST  = PREC_W'(4);
  localparam logic [CNT_W-1:0]  COUNT_RST = CNT_W'(1024);
  localparam logic [CNT_W-1:0]  COUNT_MAX = CNT_W'(PIXELS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRECISION   = 2'd0,
    REG_PIXEL_COUNT = 2'd1,
    REG_BLEND_MODE  = 2'd2,
    REG_WRAP_ENABLE = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ACT_DRAW  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    BLEND_COPY = 2'd0,
    BLEND_MAX  = 2'd1,
    BLEND_ADD  = 2'd2
  } blend_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_WR,
    ST_RDPIX
  } seq_state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [LOC_W-1:0]   location;
    logic [SPAN_W-1:0]  width;
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   pixel_index;
  } in_word_t;

  typedef struct packed {
    logic [COLOR_W-1:0] read_color;
    logic               index_valid;
  } out_word_t;

  typedef struct packed {
    logic [PREC_W-1:0] precision;
    logic [CNT_W-1:0]  pixel_count;
    logic [1:0]        blend_mode;
    logic              wrap_enable;
  } cfg_t;

  typedef struct packed {
    logic               re;
    logic               we;
    logic [PIX_AW-1:0]  addr;
    logic [COLOR_W-1:0] wdata;
  } mem_req_t;

endpackage

@@ rtl/ssb_pix_mem.sv @@
`timescale 1ns / 1ps
// ssb_pix_mem: single-port pixel store, one access per cycle, registered read
// depends on ssb_pkg

module ssb_pix_mem (
  input  logic                         clk_i,
  input  ssb_pkg::mem_req_t            req_i,
  output logic [ssb_pkg::COLOR_W-1:0]  rdata_o
);
  import ssb_pkg::*;

  logic [COLOR_W-1:0] mem_q [PIXELS];
  logic [COLOR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ssb_blend.sv @@
`timescale 1ns / 1ps
// ssb_blend: per-channel coverage scale and blend, three channel lanes
// depends on ssb_pkg

module ssb_blend (
  input  logic [ssb_pkg::COLOR_W-1:0] dst_i,
  input  logic [ssb_pkg::COLOR_W-1:0] color_i,
  input  logic [ssb_pkg::AMT_W-1:0]   amount_i,
  input  logic [ssb_pkg::PREC_W-1:0]  precision_i,
  input  logic [1:0]                  mode_i,
  output logic [ssb_pkg::COLOR_W-1:0] out_o
);
  import ssb_pkg::*;

  localparam int unsigned NCH = COLOR_W / CH_W;

  logic [AMT_W-1:0] one;
  logic             partial;

  assign one     = AMT_W'(1) << precision_i;
  assign partial = amount_i < one;

  for (genvar g = 0; g < NCH; g++) begin : g_ch
    logic [CH_W-1:0]       c;
    logic [CH_W-1:0]       d;
    logic [CH_W+AMT_W-1:0] prod;
    logic [CH_W+AMT_W-1:0] prod_sh;
    logic [CH_W-1:0]       src;
    logic [CH_W:0]         sum;
    logic [CH_W-1:0]       res;

    assign c       = color_i[g*CH_W +: CH_W];
    assign d       = dst_i[g*CH_W +: CH_W];
    assign prod    = c * amount_i;
    assign prod_sh = prod >> precision_i;
    // partial coverage keeps floor(c * amount / 2^precision), always <= c
    assign src     = partial ? prod_sh[CH_W-1:0] : c;
    assign sum     = {1'b0, src} + {1'b0, d};

    always_comb begin
      unique case (mode_i)
        BLEND_COPY: res = src;
        BLEND_MAX:  res = (src > d) ? src : d;
        default:    res = sum[CH_W] ? {CH_W{1'b1}} : sum[CH_W-1:0];
      endcase
    end

    assign out_o[g*CH_W +: CH_W] = res;
  end

endmodule

@@ rtl/ssb_seq.sv @@
`timescale 1ns / 1ps
// ssb_seq: item sequencer with clear pass, iterative modulo and pixel read-modify-write
// depends on ssb_pkg, ssb_blend

module ssb_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ssb_pkg::cfg_t                cfg_i,
  input  logic                         start_i,
  input  ssb_pkg::in_word_t            in_i,
  input  logic [ssb_pkg::COLOR_W-1:0]  mem_rdata_i,
  output ssb_pkg::mem_req_t            mem_req_o,
  output logic                         busy_o,
  output logic                         done_o,
  output ssb_pkg::out_word_t           out_o
);
  import ssb_pkg::*;

  seq_state_e state_q, state_d;

  logic [PIX_AW-1:0]  clr_q, clr_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [LOC_W-1:0]   loc_q, loc_d;
  logic [SPAN_W-1:0]  width_q, width_d;
  logic [AMT_W-1:0]   remain_q, remain_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               done_q, done_d;
  out_word_t          out_q, out_d;

  // item decode
  logic [AMT_W-1:0]  one;
  logic [CNT_W-1:0]  eff_count;
  logic [LOC_W-1:0]  in_loc;
  logic [AMT_W-1:0]  in_remain;
  logic              accept;
  logic              idx_ok;
  logic              in_loc_ok;
  logic              draw_empty;

  assign one        = AMT_W'(1) << cfg_i.precision;
  assign eff_count  = (cfg_i.pixel_count > COUNT_MAX) ? COUNT_MAX : cfg_i.pixel_count;
  assign in_loc     = in_i.location >> cfg_i.precision;
  assign in_remain  = one - (in_i.location[AMT_W-1:0] & (one - AMT_W'(1)));
  assign accept     = start_i && (state_q == ST_IDLE);
  assign idx_ok     = CNT_W'(in_i.pixel_index) < eff_count;
  assign in_loc_ok  = in_loc < LOC_W'(eff_count);
  assign draw_empty = (eff_count == '0) || (in_i.width == '0);

  // modulo step: restoring remainder, one dividend bit a cycle
  logic [CNT_W:0]   rem_sh;
  logic [CNT_W:0]   rem_n;
  logic             mod_last;

  assign rem_sh   = {rem_q, loc_q[LOC_W-1]};
  assign rem_n    = (rem_sh >= {1'b0, count_q}) ? rem_sh - {1'b0, count_q} : rem_sh;
  assign mod_last = step_q == STEP_W'(LOC_W - 1);

  // span step
  logic [AMT_W-1:0]   amount;
  logic [SPAN_W-1:0]  width_left;
  logic [LOC_W-1:0]   loc_inc;
  logic [LOC_W-1:0]   loc_next;
  logic               span_more;
  logic [COLOR_W-1:0] blend_out;

  assign amount     = (width_q < SPAN_W'(remain_q)) ? width_q[AMT_W-1:0] : remain_q;
  assign width_left = width_q - SPAN_W'(amount);
  assign loc_inc    = loc_q + LOC_W'(1);
  assign loc_next   = (cfg_i.wrap_enable && (loc_inc == LOC_W'(count_q))) ? '0 : loc_inc;
  assign span_more  = (width_left != '0) &&
                      (cfg_i.wrap_enable || (loc_inc < LOC_W'(count_q)));

  ssb_blend u_blend (
    .dst_i       (mem_rdata_i),
    .color_i     (color_q),
    .amount_i    (amount),
    .precision_i (cfg_i.precision),
    .mode_i      (cfg_i.blend_mode),
    .out_o       (blend_out)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == PIX_AW'(PIXELS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_i.action)
            ACT_DRAW: begin
              if (draw_empty) begin
                state_d = ST_IDLE;
              end else if (cfg_i.wrap_enable) begin
                state_d = ST_MOD;
              end else if (in_loc_ok) begin
                state_d = ST_RD;
              end
            end
            ACT_READ: begin
              if (idx_ok) begin
                state_d = ST_RDPIX;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_MOD: begin
        if (mod_last) begin
          state_d = ST_RD;
        end
      end
      ST_RD:    state_d = ST_WR;
      ST_WR:    state_d = span_more ? ST_RD : ST_IDLE;
      ST_RDPIX: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs: memory port and result word
  always_comb begin
    mem_req_o = '0;
    out_d     = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_req_o.we   = 1'b1;
        mem_req_o.addr = clr_q;
      end
      ST_IDLE: begin
        if (accept && idx_ok) begin
          mem_req_o.addr = in_i.pixel_index[PIX_AW-1:0];
          if (in_i.action == ACT_READ) begin
            mem_req_o.re = 1'b1;
          end
          if (in_i.action == ACT_WRITE) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.wdata = in_i.color;
            out_d.index_valid = 1'b1;
          end
        end
      end
      ST_RD: begin
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = loc_q[PIX_AW-1:0];
      end
      ST_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = loc_q[PIX_AW-1:0];
        mem_req_o.wdata = blend_out;
      end
      ST_RDPIX: begin
        out_d.read_color  = mem_rdata_i;
        out_d.index_valid = 1'b1;
      end
      default: begin
      end
    endcase
    done_d = (state_d == ST_IDLE) &&
             (accept || ((state_q != ST_IDLE) && (state_q != ST_CLEAR)));
  end

  // datapath registers
  always_comb begin
    clr_d    = clr_q;
    step_d   = step_q;
    rem_d    = rem_q;
    loc_d    = loc_q;
    width_d  = width_q;
    remain_d = remain_q;
    color_d  = color_q;
    count_d  = count_q;
    unique case (state_q)
      ST_CLEAR: clr_d = clr_q + PIX_AW'(1);
      ST_IDLE: begin
        if (accept) begin
          loc_d    = in_loc;
          width_d  = in_i.width;
          remain_d = in_remain;
          color_d  = in_i.color;
          count_d  = eff_count;
          step_d   = '0;
          rem_d    = '0;
        end
      end
      ST_MOD: begin
        rem_d  = rem_n[CNT_W-1:0];
        step_d = step_q + STEP_W'(1);
        loc_d  = mod_last ? LOC_W'(rem_n[CNT_W-1:0]) : {loc_q[LOC_W-2:0], 1'b0};
      end
      ST_WR: begin
        width_d  = width_left;
        remain_d = one;
        loc_d    = loc_next;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q   <= step_d;
    rem_q    <= rem_d;
    loc_q    <= loc_d;
    width_q  <= width_d;
    remain_q <= remain_d;
    color_q  <= color_d;
    count_q  <= count_d;
    out_q    <= out_d;
  end

  assign busy_o = state_q != ST_IDLE;
  assign done_o = done_q;
  assign out_o  = out_q;

  // span writes stay inside the pixels in use
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR) |-> (loc_q < LOC_W'(count_q)))
    else $error("span write past pixel count");

  // a span step always has sub-pixels left to place
  a_wr_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR) |-> ((width_q != '0) && (remain_q != '0) && (remain_q <= one)))
    else $error("span step with no coverage");

  // every accepted word leads to work or a result in the next cycle
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o || done_o))
    else $error("accepted word dropped");

  // a result is only flagged once per word
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$past(done_o) || $past(accept))
    else $error("repeated result strobe");

  // the remainder unit keeps its partial remainder below the divisor
  a_mod_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) |-> (rem_q < count_q))
    else $error("modulo remainder out of bound");

endmodule

@@ rtl/subpixel_span_blend_unit.sv @@
`timescale 1ns / 1ps
// subpixel_span_blend_unit: top level, configuration registers, sequencer and pixel store
// depends on ssb_pkg, ssb_seq, ssb_blend, ssb_pix_mem
//
// usage
//   command channel: a word on in_i is taken at a clock edge with start_i high and
//   busy_o low. actions are draw span, read pixel and write pixel.
//   result channel: every word gives exactly one result on out_o, flagged by done_o
//   for one cycle; the receiver has no way to hold it, so it must sample it then.
//   config port: cfg_we_i writes cfg_data_i into register cfg_index_i (precision,
//   pixel count, blend mode, wrap enable); write only while busy_o is low and no
//   result is pending.
// sequencing
//   read: the store read is issued at acceptance and its data registered from ST_RDPIX;
//   write, nop and empty draws flag done_o straight from the idle state. draw: each
//   covered pixel takes one store read and one blended write-back on the single store
//   port, after a bit-serial modulo of the location when wrap is on.
//   the block takes one word at a time; the next word is accepted once busy_o drops.
// reset
//   rst_ni is asynchronous; after release the store is cleared one pixel a cycle,
//   all 1024 pixels, with busy_o high. config registers return to their reset values
//   at once and may be written during the clear.

module subpixel_span_blend_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command channel
  input  logic                            start_i,
  input  ssb_pkg::in_word_t               in_i,
  output logic                            busy_o,
  // result channel
  output logic                            done_o,
  output ssb_pkg::out_word_t              out_o,
  // config port
  input  logic                            cfg_we_i,
  input  logic [ssb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ssb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ssb_pkg::*;

  cfg_t               cfg_q;
  mem_req_t           mem_req;
  logic [COLOR_W-1:0] mem_rdata;

  // config registers, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.precision   <= PREC_RST;
      cfg_q.pixel_count <= COUNT_RST;
      cfg_q.blend_mode  <= BLEND_COPY;
      cfg_q.wrap_enable <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PRECISION:   cfg_q.precision   <= cfg_data_i[PREC_W-1:0];
        REG_PIXEL_COUNT: cfg_q.pixel_count <= cfg_data_i[CNT_W-1:0];
        REG_BLEND_MODE:  cfg_q.blend_mode  <= cfg_data_i[1:0];
        REG_WRAP_ENABLE: cfg_q.wrap_enable <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // sequencer owns the store port: clear pass, single-pixel access and span rmw
  ssb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (start_i),
    .in_i        (in_i),
    .mem_rdata_i (mem_rdata),
    .mem_req_o   (mem_req),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .out_o       (out_o)
  );

  // 1024 x 24 pixel store
  ssb_pix_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule
